FILE: rtl/core/mrb_pkg.sv
// Shared types, codes and constants for the message ring buffer.
// No dependencies; every other file of the block imports this package.
package mrb_pkg;

  localparam int MODE_W   = 2;
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  localparam int DEF_POOL_BYTES   = 16384;
  localparam int DEF_HEADER_BYTES = 2;
  localparam int MAX_PAYLOAD      = 4096;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECV  = 2'd2;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_BYTE,
    OP_RECV,
    OP_BAD
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_ROOM,
    ST_EMPTY,
    ST_SEQ
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HDR_WR,
    BK_HDR_RD0,
    BK_HDR_RD1,
    BK_DATA_RD
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  msg_length;
    logic [BYTE_W-1:0] data_in;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

FILE: rtl/core/message_ring_buffer.sv
// Top level of the message ring buffer: joins the request front end to the
// back end that owns the byte pool. Depends on mrb_pkg, mrb_front and mrb_back.
//
//   Channel   Handshake               Payload
//   request   start_i / busy_o        mode_i, msg_length_i, data_in_i
//   result    done_o (one-cycle)      status_o, data_out_o, last_byte_o,
//                                     popped_length_o
//
// A request is taken on a rising edge with start_i high and busy_o low, and is
// queued; busy_o rises only when the request queue is full.
// The back end handles one request at a time on the byte pool: a payload byte
// send writes its byte directly, a send start that is taken then writes the
// HEADER_BYTES header bytes (one header byte is written per cycle) while a
// refused or out-of-sequence start writes nothing, and a receive answers at
// once on an empty pool, reads the payload byte of a message already open, and
// for a new message reads the two header bytes and then, unless the message is
// empty, its first payload byte, each through the registered read.
// Each result is shown for exactly one cycle with done_o high, in the cycle after
// the back end settles it; the receiver cannot stall, so nothing waits on it.
// Reset clears the pointers, the counters and the queue at once; the pool itself
// is not cleared, as only bytes that have been written are ever read back.
module message_ring_buffer #(
  parameter int POOL_BYTES   = mrb_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = mrb_pkg::DEF_HEADER_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [mrb_pkg::MODE_W-1:0]   mode_i,
  input  logic [mrb_pkg::LEN_W-1:0]    msg_length_i,
  input  logic [mrb_pkg::BYTE_W-1:0]   data_in_i,
  output logic                         done_o,
  output logic [mrb_pkg::STATUS_W-1:0] status_o,
  output logic [mrb_pkg::BYTE_W-1:0]   data_out_o,
  output logic                         last_byte_o,
  output logic [mrb_pkg::LEN_W-1:0]    popped_length_o
);
  import mrb_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_pop;
  result_t result;

  // The front end decodes the mode and queues the request.
  mrb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .mode_i       (mode_i),
    .msg_length_i (msg_length_i),
    .data_in_i    (data_in_i),
    .busy_o       (busy_o),
    .valid_o      (item_valid),
    .item_o       (item),
    .pop_i        (item_pop)
  );

  // The back end owns the pool and all pointer state.
  mrb_back #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (item_valid),
    .item_i   (item),
    .pop_o    (item_pop),
    .done_o   (done_o),
    .result_o (result)
  );

  assign status_o        = result.status;
  assign data_out_o      = result.data;
  assign last_byte_o     = result.last;
  assign popped_length_o = result.length;

endmodule

FILE: rtl/core/mrb_front.sv
// Front end of the message ring buffer: takes requests, decodes the mode and
// holds them in a short queue for the back end. Depends on mrb_pkg.
module mrb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mrb_pkg::MODE_W-1:0] mode_i,
  input  logic [mrb_pkg::LEN_W-1:0]  msg_length_i,
  input  logic [mrb_pkg::BYTE_W-1:0] data_in_i,
  output logic                       busy_o,
  output logic                       valid_o,
  output mrb_pkg::item_t             item_o,
  input  logic                       pop_i
);
  import mrb_pkg::*;

  localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entry_q [QUEUE_DEPTH];
  logic [QI_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  count_q, count_d;
  item_t            item_new;
  logic             push;

  always_comb begin
    item_new.msg_length = msg_length_i;
    item_new.data_in    = data_in_i;
    case (mode_i)
      MODE_BEGIN: item_new.op = OP_BEGIN;
      MODE_BYTE:  item_new.op = OP_BYTE;
      MODE_RECV:  item_new.op = OP_RECV;
      default:    item_new.op = OP_BAD;
    endcase
  end

  assign busy_o  = (count_q == QC_W'(QUEUE_DEPTH));
  assign push    = start_i && !busy_o;
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QI_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i && valid_o) begin
      rd_ptr_d = (rd_ptr_q == QI_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !(pop_i && valid_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i && valid_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

FILE: rtl/core/mrb_back.sv
// Back end of the message ring buffer: owns the byte pool and the pointers,
// carries out each queued request and registers its result. Depends on mrb_pkg.
module mrb_back #(
  parameter int POOL_BYTES   = mrb_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = mrb_pkg::DEF_HEADER_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mrb_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             done_o,
  output mrb_pkg::result_t result_o
);
  import mrb_pkg::*;

  localparam int PW   = $clog2(POOL_BYTES);
  localparam int HC_W = $clog2(HEADER_BYTES);
  localparam int SW   = ((PW > 17) ? PW : 17) + 2;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] x);
    return (x == PW'(POOL_BYTES - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [PW-1:0] wrap_hdr(input logic [PW-1:0] x);
    logic [PW:0] s;
    s = {1'b0, x} + (PW+1)'(HEADER_BYTES);
    return (s >= (PW+1)'(POOL_BYTES)) ? PW'(s - (PW+1)'(POOL_BYTES)) : PW'(s);
  endfunction

  logic [BYTE_W-1:0] pool_q [POOL_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  back_state_e      state_q, state_d;
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0]    wpos_q, wpos_d, rpos_q, rpos_d;
  logic [LEN_W-1:0] send_left_q, send_left_d, send_len_q, send_len_d;
  logic [LEN_W-1:0] recv_left_q, recv_left_d, recv_len_q, recv_len_d;
  logic [HC_W-1:0]  hcnt_q, hcnt_d;
  logic [BYTE_W-1:0] b0_q, b0_d;
  logic             done_q, done_d;
  result_t          res_q, res_d;

  logic              we, re;
  logic [PW-1:0]     waddr, raddr;
  logic [BYTE_W-1:0] wdata;
  logic [PW:0]       used_wide;
  logic [PW-1:0]     used;
  logic [SW-1:0]     need;
  logic              reject;
  logic [PW-1:0]     rp_hdr;
  logic [LEN_W-1:0]  hdr_len;
  logic [BYTE_W-1:0] hdr_byte;

  // Committed bytes in the pool, taken modulo the pool size.
  assign used_wide = {1'b0, wp_q} + ((wp_q < rp_q) ? (PW+1)'(POOL_BYTES) : '0)
                     - {1'b0, rp_q};
  assign used      = used_wide[PW-1:0];
  assign need      = SW'(used) + SW'(HEADER_BYTES) + SW'(item_i.msg_length);
  assign reject    = (SW'(item_i.msg_length) > SW'(MAX_PAYLOAD)) ||
                     (need > SW'(POOL_BYTES - 1));
  assign rp_hdr    = wrap_hdr(rp_q);
  assign hdr_len   = {rdata_q[LEN_W-BYTE_W-1:0], b0_q};

  always_comb begin
    if (hcnt_q == HC_W'(0)) begin
      hdr_byte = send_len_q[BYTE_W-1:0];
    end else if (hcnt_q == HC_W'(1)) begin
      hdr_byte = BYTE_W'(send_len_q[LEN_W-1:BYTE_W]);
    end else begin
      hdr_byte = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    send_left_d = send_left_q;
    send_len_d  = send_len_q;
    recv_left_d = recv_left_q;
    recv_len_d  = recv_len_q;
    hcnt_d      = hcnt_q;
    b0_d        = b0_q;
    done_d      = 1'b0;
    res_d       = '{status: ST_OK, data: '0, last: 1'b0, length: '0};
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = wpos_q;
    wdata       = '0;
    re          = 1'b0;
    raddr       = rpos_q;

    case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          case (item_i.op)
            OP_BEGIN: begin
              done_d = 1'b1;
              if (send_left_q != '0) begin
                res_d.status = ST_SEQ;
              end else if (reject) begin
                res_d.status = ST_NO_ROOM;
              end else begin
                send_len_d = item_i.msg_length;
                wpos_d     = wp_q;
                hcnt_d     = '0;
                state_d    = BK_HDR_WR;
              end
            end
            OP_BYTE: begin
              done_d = 1'b1;
              if (send_left_q == '0) begin
                res_d.status = ST_SEQ;
              end else begin
                we          = 1'b1;
                waddr       = wpos_q;
                wdata       = item_i.data_in;
                wpos_d      = wrap_inc(wpos_q);
                send_left_d = send_left_q - 1'b1;
                if (send_left_q == LEN_W'(1)) begin
                  wp_d = wrap_inc(wpos_q);
                end
              end
            end
            OP_RECV: begin
              if (recv_left_q == '0) begin
                if (wp_q == rp_q) begin
                  done_d       = 1'b1;
                  res_d.status = ST_EMPTY;
                end else begin
                  re      = 1'b1;
                  raddr   = rp_q;
                  state_d = BK_HDR_RD0;
                end
              end else begin
                re      = 1'b1;
                raddr   = rpos_q;
                rpos_d  = wrap_inc(rpos_q);
                state_d = BK_DATA_RD;
              end
            end
            default: begin
              done_d       = 1'b1;
              res_d.status = ST_SEQ;
            end
          endcase
        end
      end
      BK_HDR_WR: begin
        we     = 1'b1;
        waddr  = wpos_q;
        wdata  = hdr_byte;
        wpos_d = wrap_inc(wpos_q);
        hcnt_d = hcnt_q + 1'b1;
        if (hcnt_q == HC_W'(HEADER_BYTES - 1)) begin
          state_d = BK_IDLE;
          if (send_len_q == '0) begin
            wp_d = wrap_inc(wpos_q);
          end else begin
            send_left_d = send_len_q;
          end
        end
      end
      BK_HDR_RD0: begin
        b0_d    = rdata_q;
        re      = 1'b1;
        raddr   = wrap_inc(rp_q);
        state_d = BK_HDR_RD1;
      end
      BK_HDR_RD1: begin
        if (hdr_len == '0) begin
          rp_d       = rp_hdr;
          recv_len_d = '0;
          done_d     = 1'b1;
          res_d.last = 1'b1;
          state_d    = BK_IDLE;
        end else begin
          recv_len_d  = hdr_len;
          recv_left_d = hdr_len;
          re          = 1'b1;
          raddr       = rp_hdr;
          rpos_d      = wrap_inc(rp_hdr);
          state_d     = BK_DATA_RD;
        end
      end
      BK_DATA_RD: begin
        recv_left_d  = recv_left_q - 1'b1;
        done_d       = 1'b1;
        res_d.data   = rdata_q;
        res_d.length = recv_len_q;
        state_d      = BK_IDLE;
        if (recv_left_q == LEN_W'(1)) begin
          res_d.last = 1'b1;
          rp_d       = rpos_q;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      send_left_q <= '0;
      recv_left_q <= '0;
      recv_len_q  <= '0;
      hcnt_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      send_left_q <= send_left_d;
      recv_left_q <= recv_left_d;
      recv_len_q  <= recv_len_d;
      hcnt_q      <= hcnt_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wpos_q     <= wpos_d;
    rpos_q     <= rpos_d;
    send_len_q <= send_len_d;
    b0_q       <= b0_d;
    res_q      <= res_d;
  end

  // Byte pool: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      pool_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= pool_q[raddr];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_data_rd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DATA_RD |=> done_q)
    else $error("payload read finished without a result strobe");

  a_hdr_rd_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_HDR_RD0 |=> state_q == BK_HDR_RD1)
    else $error("header read sequence broken");

  a_hdr_wr_idle_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_HDR_WR |-> send_left_q == '0)
    else $error("header written while a send is still open");

  a_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == ST_EMPTY) |-> wp_q == rp_q)
    else $error("empty reported while committed messages remain");

endmodule

FILE: test/tb_message_ring_buffer.sv
// Self-checking testbench for message_ring_buffer: requests, a behavioural model of the
// byte pool that predicts each response, and a checker of the response strobe.
// Depends on mrb_pkg and the message_ring_buffer RTL only.
module tb_message_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import mrb_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          POOL           = DEF_POOL_BYTES;
  localparam int          HDR            = DEF_HEADER_BYTES;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned TAIL_ITEMS     = 200;
  localparam int unsigned LONG_LEN       = 100;
  // The worst quiet spell in a correct run is a random request gap plus the
  // back-end work on each queued request, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 20;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start_i      = 1'b0;
  logic [MODE_W-1:0]   mode_i       = '0;
  logic [LEN_W-1:0]    msg_length_i = '0;
  logic [BYTE_W-1:0]   data_in_i    = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [BYTE_W-1:0]   data_out_o;
  logic                last_byte_o;
  logic [LEN_W-1:0]    popped_length_o;

  message_ring_buffer #(
    .POOL_BYTES  (POOL),
    .HEADER_BYTES(HDR)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .msg_length_i   (msg_length_i),
    .data_in_i      (data_in_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .last_byte_o    (last_byte_o),
    .popped_length_o(popped_length_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Behavioural copy of the ring buffer. The write pointer marks the committed
  // end of the pool: a message only becomes visible to the receive side once its
  // last payload byte has arrived. One pool byte is always kept free.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] pool_mirror [POOL];
  int unsigned       wr_ptr, rd_ptr;
  int unsigned       send_left, send_len;
  int unsigned       recv_left, recv_len;

  result_t     replies_due [$];
  int unsigned idle_pct;
  int unsigned n_requests, n_mismatches, n_msgs_popped;
  int unsigned n_status [4];
  int unsigned quiet_cycles;

  function automatic int unsigned pool_used();
    return (wr_ptr + POOL - rd_ptr) % POOL;
  endfunction

  // Works out the response to one request and advances the mirrored state.
  function automatic result_t ring_reply(op_e op, logic [LEN_W-1:0] len,
                                         logic [BYTE_W-1:0] din);
    result_t     r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_BEGIN: begin
        if (send_left != 0) begin
          r.status = ST_SEQ;
        end else if (len > MAX_PAYLOAD || pool_used() + HDR + len > POOL - 1) begin
          r.status = ST_NO_ROOM;
        end else begin
          // The header carries the length, low byte first; any further bytes are zero.
          for (int i = 0; i < HDR; i++) begin
            pool_mirror[(wr_ptr + i) % POOL] = (i == 0) ? len[BYTE_W-1:0] :
                                               (i == 1) ? BYTE_W'(len >> BYTE_W) : '0;
          end
          if (len == 0) begin
            wr_ptr = (wr_ptr + HDR) % POOL;
          end else begin
            send_len  = len;
            send_left = len;
          end
        end
      end
      OP_BYTE: begin
        if (send_left == 0) begin
          r.status = ST_SEQ;
        end else begin
          pos = (wr_ptr + HDR + send_len - send_left) % POOL;
          pool_mirror[pos] = din;
          send_left--;
          if (send_left == 0) wr_ptr = (wr_ptr + HDR + send_len) % POOL;
        end
      end
      OP_RECV: begin
        if (recv_left == 0 && wr_ptr == rd_ptr) begin
          r.status = ST_EMPTY;
        end else begin
          if (recv_left == 0) begin
            recv_len  = LEN_W'({pool_mirror[(rd_ptr + 1) % POOL], pool_mirror[rd_ptr]});
            recv_left = recv_len;
          end
          if (recv_len == 0) begin
            // An empty message is consumed in one pop, flagged as its own end.
            rd_ptr = (rd_ptr + HDR) % POOL;
            r.last = 1'b1;
          end else begin
            pos = (rd_ptr + HDR + recv_len - recv_left) % POOL;
            r.data   = pool_mirror[pos];
            r.length = LEN_W'(recv_len);
            recv_left--;
            if (recv_left == 0) begin
              r.last = 1'b1;
              rd_ptr = (rd_ptr + HDR + recv_len) % POOL;
            end
          end
        end
      end
      default: r.status = ST_SEQ;
    endcase
    return r;
  endfunction

  // Presents one request, holds it until it is taken, then records its response.
  // Called at a rising edge; start_i gets exactly one assignment per time step.
  task automatic send_request(op_e op, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] din);
    result_t r;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    mode_i       <= op;
    msg_length_i <= len;
    data_in_i    <= din;
    do @(posedge clk_i); while (busy_o);
    r = ring_reply(op, len, din);
    replies_due.push_back(r);
    n_requests++;
  endtask

  function automatic void report_mismatch(string field, logic [15:0] want, logic [15:0] got);
    n_mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // Every strobed response is taken against the oldest outstanding prediction.
  always @(posedge clk_i) begin : reply_checker
    result_t want;
    if (rst_ni && done_o) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected response, status", '0, status_o);
      end else begin
        want = replies_due.pop_front();
        n_status[want.status]++;
        if (want.status == ST_OK && want.last) n_msgs_popped++;
        if (status_o !== want.status)       report_mismatch("status", want.status, status_o);
        if (data_out_o !== want.data)       report_mismatch("data_out", want.data, data_out_o);
        if (last_byte_o !== want.last)      report_mismatch("last_byte", want.last, last_byte_o);
        if (popped_length_o !== want.length)
          report_mismatch("popped_length", want.length, popped_length_o);
      end
    end
  end

  // Ends a hung run: no request taken and no response seen for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Protocol corner cases on a near-empty pool: errors, length limits, the empty
  // message and a message that stays invisible until its last byte is sent.
  task automatic test_protocol_corners();
    idle_pct = 0;
    send_request(OP_RECV,  '1, '1);                     // pool empty
    send_request(OP_BYTE,  '0, 8'hff);                  // payload with no send open
    send_request(OP_BAD,   '1, '1);                     // unused mode
    send_request(OP_BEGIN, LEN_W'(MAX_PAYLOAD + 1), '0); // just too long
    send_request(OP_BEGIN, '1, '0);                     // largest length field
    send_request(OP_BEGIN, '0, '0);                     // empty message commits at once
    send_request(OP_RECV,  '0, '0);
    send_request(OP_RECV,  '0, '0);
    send_request(OP_BEGIN, LEN_W'(3), '0);
    send_request(OP_RECV,  '0, '0);                     // not yet committed, so empty
    send_request(OP_BEGIN, LEN_W'(5), '0);              // a send is already open
    send_request(OP_BYTE,  '0, 8'h00);
    send_request(OP_BYTE,  '1, 8'hff);
    send_request(OP_RECV,  '1, '0);
    send_request(OP_BYTE,  '0, 8'ha5);
    send_request(OP_BYTE,  '0, 8'h5a);                  // send already complete
    idle_pct = 30;
    repeat (3) send_request(OP_RECV, '0, '0);
    send_request(OP_RECV, '0, '0);
  endtask

  // A long message stays hidden from the receive side until its last byte is
  // in, then is read out whole with its length shown on every byte.
  task automatic test_long_message();
    idle_pct = 5;
    send_request(OP_BEGIN, LEN_W'(LONG_LEN), '0);
    repeat (LONG_LEN - 1) send_request(OP_BYTE, LEN_W'($urandom), BYTE_W'($urandom));
    send_request(OP_RECV, '0, '0);                      // still empty
    send_request(OP_BYTE, '0, BYTE_W'($urandom));
    while (pool_used() != 0 || recv_left != 0) send_request(OP_RECV, '0, '0);
    send_request(OP_RECV, '0, '0);
  endtask

  // One item that the block should refuse, or a stray receive request.
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_request(OP_BAD, LEN_W'($urandom), BYTE_W'($urandom));
      1: send_request(OP_BYTE, LEN_W'($urandom), BYTE_W'($urandom));
      2: send_request(OP_BEGIN, LEN_W'($urandom_range(8191, MAX_PAYLOAD + 1)),
                      BYTE_W'($urandom));
      default: send_request(OP_RECV, LEN_W'($urandom), BYTE_W'($urandom));
    endcase
  endtask

  // Mostly complete messages of random length and content interleaved with
  // bursts of receive requests, plus a sprinkling of broken sequences.
  task automatic test_mixed_traffic(int unsigned items, bit with_gaps);
    int unsigned target, pick, len;
    target = n_requests + items;
    while (n_requests < target) begin
      idle_pct = (with_gaps && $urandom_range(3) != 0) ? 20 : 0;
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(99);
        len  = (pick < 60) ? $urandom_range(6) :
               (pick < 92) ? $urandom_range(40, 7) :
               (pick < 99) ? $urandom_range(120, 41) : $urandom_range(400, 121);
        send_request(OP_BEGIN, LEN_W'(len), BYTE_W'($urandom));
        while (send_left != 0) begin
          pick = $urandom_range(99);
          if (pick < 4)      send_request(OP_BEGIN, LEN_W'($urandom), BYTE_W'($urandom));
          else if (pick < 10) send_request(OP_RECV, LEN_W'($urandom), BYTE_W'($urandom));
          send_request(OP_BYTE, LEN_W'($urandom), BYTE_W'($urandom));
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(12, 1))
          send_request(OP_RECV, LEN_W'($urandom), BYTE_W'($urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_protocol_corners();
    test_long_message();
    test_mixed_traffic(RANDOM_ITEMS - TAIL_ITEMS, 1'b1);
    // Closing stretch at full request rate.
    test_mixed_traffic(TAIL_ITEMS, 1'b0);

    start_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d ok, %0d refused, %0d empty, %0d out of sequence.",
             n_requests, n_status[ST_OK], n_status[ST_NO_ROOM], n_status[ST_EMPTY],
             n_status[ST_SEQ]);
    $display("%0d messages read out whole, one of them %0d bytes long.",
             n_msgs_popped, LONG_LEN);
    if (n_mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: message_ring_buffer.f
rtl/core/mrb_pkg.sv
rtl/core/mrb_front.sv
rtl/core/mrb_back.sv
rtl/core/message_ring_buffer.sv
test/tb_message_ring_buffer.sv
